// ===== rtl/periodic_task_scheduler_unit_assert.svh =====
// assertion macros for the periodic task scheduler
// depends on nothing; included by the top level
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PTS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/pts_pkg.sv =====
// types and constants for the periodic task scheduler
// depends on nothing
`default_nettype none
package pts_pkg;
    localparam int SLOT_COUNT_DEF = 8;
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_PAUSE = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_SET_PERIOD = 3'd5;
    localparam logic [2:0] OP_RUN_NOW = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  task_key;
        logic [31:0] period;
        logic        start_enabled;
        logic        start_at_once;
        logic [31:0] now_time;
    } request_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] fired_key;
        logic       ok;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_scan;
        logic step_scan;
        logic exec;
        logic emit_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_end;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/pts_datapath.sv =====
// slot table, key lookup, tick scan and result register
// depends on pts_pkg
`default_nettype none
module pts_datapath
    import pts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  request_t      req,
    input  cmd_t          cmd,
    output stat_t         stat,
    output logic          result_valid,
    output result_t       result
);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    request_t              req_reg;
    logic [SLOT_COUNT-1:0] used_reg, enabled_reg, at_once_reg;
    logic [7:0]            key_reg [SLOT_COUNT];
    logic [31:0]           period_reg [SLOT_COUNT];
    logic [31:0]           last_reg [SLOT_COUNT];
    logic [CW-1:0]         scan_reg;
    logic                  hit_reg, free_ok_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               out_next;

    logic          hit, free_ok;
    logic [IW-1:0] hit_idx, free_idx;
    logic [IW-1:0] si;
    logic          fire;
    logic          run_fire;

    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (used_reg[i] && key_reg[i] == req_reg.task_key)
            begin
                hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!used_reg[i])
            begin
                free_ok = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign si = scan_reg[IW-1:0];
    assign fire = (scan_reg < CW'(SLOT_COUNT)) && used_reg[si] && enabled_reg[si]
        && (at_once_reg[si] || (req_reg.now_time - last_reg[si] >= period_reg[si]));
    assign run_fire = cmd.exec && req_reg.op == OP_RUN_NOW && hit;
    assign stat.is_tick = (req_reg.op == OP_TICK);
    assign stat.scan_end = (scan_reg >= CW'(SLOT_COUNT));

    always_comb
    begin
        out_next = '0;
        if (cmd.step_scan && fire)
        begin
            out_next.kind = 1'b1;
            out_next.fired_key = key_reg[si];
            out_next.ok = 1'b1;
        end
        if (run_fire)
        begin
            out_next.kind = 1'b1;
            out_next.fired_key = req_reg.task_key;
            out_next.ok = 1'b1;
        end
        if (cmd.emit_status)
        begin
            out_next.last = 1'b1;
            case (req_reg.op)
                OP_TICK: out_next.ok = 1'b1;
                OP_ADD: out_next.ok = req_reg.period != 0 && !hit_reg && free_ok_reg;
                OP_REMOVE, OP_PAUSE, OP_RESUME, OP_RUN_NOW: out_next.ok = hit_reg;
                OP_SET_PERIOD: out_next.ok = hit_reg && req_reg.period != 0;
                default: out_next.ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        hit_reg <= hit;
        free_ok_reg <= free_ok;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            enabled_reg <= '0;
            at_once_reg <= '0;
            scan_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                key_reg[i] <= '0;
                period_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= (cmd.step_scan && fire) || cmd.emit_status || run_fire;
            if (cmd.clear_scan)
                scan_reg <= '0;
            else if (cmd.step_scan)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (fire)
                begin
                    at_once_reg[si] <= 1'b0;
                    last_reg[si] <= req_reg.now_time;
                end
            end
            if (cmd.exec)
            begin
                case (req_reg.op)
                    OP_ADD:
                        if (req_reg.period != 0 && !hit && free_ok)
                        begin
                            used_reg[free_idx] <= 1'b1;
                            key_reg[free_idx] <= req_reg.task_key;
                            period_reg[free_idx] <= req_reg.period;
                            last_reg[free_idx] <= req_reg.now_time;
                            enabled_reg[free_idx] <= req_reg.start_enabled;
                            at_once_reg[free_idx] <= req_reg.start_at_once;
                        end
                    OP_REMOVE:
                        if (hit)
                        begin
                            used_reg[hit_idx] <= 1'b0;
                            key_reg[hit_idx] <= '0;
                        end
                    OP_PAUSE:
                        if (hit)
                            enabled_reg[hit_idx] <= 1'b0;
                    OP_RESUME:
                        if (hit)
                        begin
                            enabled_reg[hit_idx] <= 1'b1;
                            last_reg[hit_idx] <= req_reg.now_time;
                        end
                    OP_SET_PERIOD:
                        if (hit && req_reg.period != 0)
                            period_reg[hit_idx] <= req_reg.period;
                    OP_RUN_NOW:
                        if (hit)
                            last_reg[hit_idx] <= req_reg.now_time;
                    default: ;
                endcase
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;
endmodule
`default_nettype wire

// ===== rtl/pts_controller.sv =====
// sequencing state machine of the scheduler
// depends on pts_pkg
`default_nettype none
module pts_controller
    import pts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  stat_t     stat,
    output cmd_t      cmd,
    output logic      busy
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.clear_scan = 1'b1;
                state_next = stat.is_tick ? ST_SCAN : ST_DONE;
                cmd.exec = !stat.is_tick;
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                    state_next = ST_DONE;
                else
                    cmd.step_scan = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit_status = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/periodic_task_scheduler_unit.sv =====
// periodic task scheduler, top level
// depends on pts_pkg, pts_controller, pts_datapath and the assertion header
//
// usage: drive req and raise start while busy is low; the request is taken
// at that edge. results come on result with result_valid high for one cycle
// each: any fired tasks first, then one status result with last set.
// a tick goes through lookup, a scan of the table at one slot per cycle
// and done before busy drops; other requests go through lookup and done.
// run now on a found key gives a fire result then the status result.
// busy drops in the cycle in which the status result is shown.
// the receiver cannot stall; results are never held.
// reset clears the slot table at once; no sweep is needed.
`default_nettype none
`include "periodic_task_scheduler_unit_assert.svh"
module periodic_task_scheduler_unit
    import pts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  request_t  req,
    output logic      result_valid,
    output result_t   result
);
    cmd_t  cmd;
    stat_t stat;
    logic  status_shown;
    logic  fire_shown;

    pts_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
    );

    pts_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .stat(stat),
        .result_valid(result_valid), .result(result)
    );

    assign status_shown = result_valid && result.last;
    assign fire_shown = result_valid && result.kind;

    `PTS_ASSERT_NEXT(a_status_ends, clk, rst_n, cmd.emit_status, status_shown, "status missing")
    `PTS_ASSERT_IMPL(a_last_idle, clk, rst_n, status_shown |-> !cmd.emit_status, "last overlaps")
    `PTS_ASSERT_IMPL(a_kind_ok, clk, rst_n, fire_shown |-> (result.ok && !result.last), "bad fire")
endmodule
`default_nettype wire
